FILE: src/uirb_pkg.sv
`timescale 1ns / 1ps
// Package for the UART ring buffer block: ring sizes, widths, operation and
// status codes. No dependencies.
package uirb_pkg;

  // Ring sizes and channel count
  localparam int RX_DEPTH = 4096;
  localparam int TX_DEPTH = 4096;
  localparam int CHANNELS = 2;

  // Widths of the item fields
  localparam int OP_W   = 2;
  localparam int CH_W   = 1;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;

  // Pointer, count and RAM address widths
  localparam int RX_PTR_W  = $clog2(RX_DEPTH);
  localparam int TX_PTR_W  = $clog2(TX_DEPTH);
  localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
  localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);
  localparam int RX_ADDR_W = CH_W + RX_PTR_W;
  localparam int TX_ADDR_W = CH_W + TX_PTR_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RECV    = 2'd2,
    OP_TXEMPTY = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

FILE: src/uirb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response words.
// Depends on uirb_pkg.
interface uirb_req_if;
  import uirb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output op, output channel, output data, input ready);
  modport sink   (input valid, input op, input channel, input data, output ready);
endinterface

interface uirb_rsp_if;
  import uirb_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [BYTE_W-1:0] read_data;
  logic              line_valid;
  logic [BYTE_W-1:0] line_byte;

  modport source (output valid, output status, output read_data, output line_valid,
                  output line_byte, input ready);
  modport sink   (input valid, input status, input read_data, input line_valid,
                  input line_byte, output ready);
endinterface

FILE: src/uirb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module uirb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read data held until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/uart_interrupt_ring_buffers.sv
`timescale 1ns / 1ps
// Per-channel receive and transmit rings for a serial port, kept in two RAMs.
// Depends on uirb_pkg, uirb_if and uirb_ram.
//
//   channel | dir | word contents
//   --------+-----+-----------------------------------------------
//   req     | in  | op, channel, data
//   rsp     | out | status, read_data, line_valid, line_byte
//
// One request word is taken per cycle while no response stall holds it back;
// its response passes the RAM read stage, then the output register. Ring state
// is updated in the accept cycle, so a pop that follows a push to the same
// entry reads the new byte. Synchronous reset empties all rings; no clearing
// pass is needed. A stalled response holds the output register and, behind it,
// the one-word stage that waits on the RAM read data.
module uart_interrupt_ring_buffers (
  input  logic      clk,
  input  logic      rst,
  uirb_req_if.sink   req,
  uirb_rsp_if.source rsp
);
  import uirb_pkg::*;

  // Per-channel ring pointers and flags
  logic [RX_PTR_W-1:0] rx_head     [CHANNELS];
  logic [RX_PTR_W-1:0] rx_tail     [CHANNELS];
  logic [RX_CNT_W-1:0] rx_count    [CHANNELS];
  logic                rx_overflow [CHANNELS];
  logic [TX_PTR_W-1:0] tx_head     [CHANNELS];
  logic [TX_PTR_W-1:0] tx_tail     [CHANNELS];
  logic [TX_CNT_W-1:0] tx_count    [CHANNELS];
  logic                tx_busy     [CHANNELS];

  // Values for the addressed channel after this word
  logic [RX_PTR_W-1:0] rx_head_next;
  logic [RX_PTR_W-1:0] rx_tail_next;
  logic [RX_CNT_W-1:0] rx_count_next;
  logic                rx_overflow_next;
  logic [TX_PTR_W-1:0] tx_head_next;
  logic [TX_PTR_W-1:0] tx_tail_next;
  logic [TX_CNT_W-1:0] tx_count_next;
  logic                tx_busy_next;

  // RAM controls
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_q, tx_q;

  // Handshake
  logic accept, out_free;

  // Decode results of the accepted word
  status_t           dec_status;
  logic              dec_line_valid;
  logic [BYTE_W-1:0] dec_line_byte;
  logic              dec_rx_pop, dec_tx_pop;
  logic              chan_ok;
  op_t               op;

  // Stage waiting on the RAM read
  logic              s1_valid;
  status_t           s1_status;
  logic              s1_line_valid;
  logic [BYTE_W-1:0] s1_line_byte;
  logic              s1_rx_pop, s1_tx_pop;

  // Output register
  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_read_data;
  logic              out_line_valid;
  logic [BYTE_W-1:0] out_line_byte;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || out_free;
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.op);
  assign chan_ok   = int'(req.channel) < CHANNELS;

  // Ring operation for the addressed channel
  always_comb begin
    rx_head_next     = rx_head[req.channel];
    rx_tail_next     = rx_tail[req.channel];
    rx_count_next    = rx_count[req.channel];
    rx_overflow_next = rx_overflow[req.channel];
    tx_head_next     = tx_head[req.channel];
    tx_tail_next     = tx_tail[req.channel];
    tx_count_next    = tx_count[req.channel];
    tx_busy_next     = tx_busy[req.channel];
    dec_status       = ST_OK;
    dec_line_valid   = 1'b0;
    dec_line_byte    = '0;
    dec_rx_pop       = 1'b0;
    dec_tx_pop       = 1'b0;
    rx_we            = 1'b0;
    rx_re            = 1'b0;
    tx_we            = 1'b0;
    tx_re            = 1'b0;
    if (chan_ok) begin
      case (op)
        OP_WRITE: begin
          // full is checked before busy
          if (tx_count[req.channel] == TX_CNT_W'(TX_DEPTH)) begin
            dec_status = ST_FULL;
          end else if (!tx_busy[req.channel]) begin
            dec_line_valid = 1'b1;
            dec_line_byte  = req.data;
            tx_busy_next   = 1'b1;
          end else begin
            tx_we         = accept;
            tx_head_next  = (tx_head[req.channel] == TX_PTR_W'(TX_DEPTH - 1)) ?
                            '0 : tx_head[req.channel] + 1'b1;
            tx_count_next = tx_count[req.channel] + 1'b1;
          end
        end
        OP_READ: begin
          if (rx_overflow[req.channel]) begin
            dec_status = ST_OVERFLOW;
          end else if (rx_count[req.channel] != '0) begin
            rx_re         = accept;
            dec_rx_pop    = 1'b1;
            rx_tail_next  = (rx_tail[req.channel] == RX_PTR_W'(RX_DEPTH - 1)) ?
                            '0 : rx_tail[req.channel] + 1'b1;
            rx_count_next = rx_count[req.channel] - 1'b1;
          end else begin
            dec_status = ST_EMPTY;
          end
        end
        OP_RECV: begin
          if (rx_count[req.channel] == RX_CNT_W'(RX_DEPTH)) begin
            rx_overflow_next = 1'b1;
          end else begin
            rx_we            = accept;
            rx_head_next     = (rx_head[req.channel] == RX_PTR_W'(RX_DEPTH - 1)) ?
                               '0 : rx_head[req.channel] + 1'b1;
            rx_count_next    = rx_count[req.channel] + 1'b1;
            rx_overflow_next = 1'b0;
          end
        end
        OP_TXEMPTY: begin
          if (tx_count[req.channel] != '0) begin
            tx_re          = accept;
            dec_tx_pop     = 1'b1;
            dec_line_valid = 1'b1;
            tx_tail_next   = (tx_tail[req.channel] == TX_PTR_W'(TX_DEPTH - 1)) ?
                             '0 : tx_tail[req.channel] + 1'b1;
            tx_count_next  = tx_count[req.channel] - 1'b1;
            tx_busy_next   = 1'b1;
          end else begin
            tx_busy_next = 1'b0;
          end
        end
        default: begin
          dec_status = ST_OK;
        end
      endcase
    end
  end

  // Ring state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rx_head[i]     <= '0;
        rx_tail[i]     <= '0;
        rx_count[i]    <= '0;
        rx_overflow[i] <= 1'b0;
        tx_head[i]     <= '0;
        tx_tail[i]     <= '0;
        tx_count[i]    <= '0;
        tx_busy[i]     <= 1'b0;
      end
    end else if (accept && chan_ok) begin
      rx_head[req.channel]     <= rx_head_next;
      rx_tail[req.channel]     <= rx_tail_next;
      rx_count[req.channel]    <= rx_count_next;
      rx_overflow[req.channel] <= rx_overflow_next;
      tx_head[req.channel]     <= tx_head_next;
      tx_tail[req.channel]     <= tx_tail_next;
      tx_count[req.channel]    <= tx_count_next;
      tx_busy[req.channel]     <= tx_busy_next;
    end
  end

  // Ring storage: all channels share one RAM per direction
  uirb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** RX_ADDR_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr ({req.channel, rx_head[req.channel]}),
    .wdata (req.data),
    .re    (rx_re),
    .raddr ({req.channel, rx_tail[req.channel]}),
    .rdata (rx_q)
  );

  uirb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** TX_ADDR_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr ({req.channel, tx_head[req.channel]}),
    .wdata (req.data),
    .re    (tx_re),
    .raddr ({req.channel, tx_tail[req.channel]}),
    .rdata (tx_q)
  );

  // Stage 1: decoded result waits for the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status     <= dec_status;
      s1_line_valid <= dec_line_valid;
      s1_line_byte  <= dec_line_byte;
      s1_rx_pop     <= dec_rx_pop;
      s1_tx_pop     <= dec_tx_pop;
    end
  end

  // Output register: merge in popped bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_status     <= s1_status;
      out_read_data  <= s1_rx_pop ? rx_q : '0;
      out_line_valid <= s1_line_valid;
      out_line_byte  <= s1_tx_pop ? tx_q : s1_line_byte;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_data  = out_read_data;
  assign rsp.line_valid = out_line_valid;
  assign rsp.line_byte  = out_line_byte;

`ifndef SYNTH
  // Ring counts never pass the ring depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> (rx_count[req.channel] <= RX_CNT_W'(RX_DEPTH)) &&
               (tx_count[req.channel] <= TX_CNT_W'(TX_DEPTH)))
    else $error("ring count beyond depth");

  // A read while overflow is set reports the overflow error
  a_overflow_read: assert property (@(posedge clk) disable iff (rst)
    (accept && chan_ok && op == OP_READ && rx_overflow[req.channel])
      |=> (s1_status == ST_OVERFLOW) && !s1_rx_pop)
    else $error("overflow not reported on read");

  // A word never pops from both rings
  a_single_pop: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_rx_pop && s1_tx_pop))
    else $error("both rings popped");

  // A popped transmit byte always shows as line_valid
  a_tx_pop_line: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_tx_pop && out_free) |=> out_line_valid)
    else $error("transmit pop without line_valid");
`endif

endmodule

FILE: sim/tb_uart_interrupt_ring_buffers.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_interrupt_ring_buffers: directed table, random traffic
// and short queue bursts, each response checked against a fixed row or the ring predictor.
// Depends on uirb_pkg, uirb_if and the block itself.
module tb_uart_interrupt_ring_buffers;
  import uirb_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_WORDS = 1350;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_GAP      = 10;
  localparam int DIR_ROWS     = 21;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] read_data;
    logic              line_valid;
    logic [BYTE_W-1:0] line_byte;
  } uart_result_t;

  typedef struct {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] data;
    bit                fixed;
    status_t           st;
    logic [BYTE_W-1:0] rd;
    logic              lv;
    logic [BYTE_W-1:0] lb;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uirb_req_if req_bus ();
  uirb_rsp_if rsp_bus ();

  uart_interrupt_ring_buffers u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #5 clk = ~clk;

  // Predicted ring state, one pair of rings per channel
  logic [BYTE_W-1:0]   rx_ring   [CHANNELS][RX_DEPTH];
  logic [BYTE_W-1:0]   tx_ring   [CHANNELS][TX_DEPTH];
  logic [RX_PTR_W-1:0] rx_wr_ptr [CHANNELS] = '{default: '0};
  logic [RX_PTR_W-1:0] rx_rd_ptr [CHANNELS] = '{default: '0};
  logic [RX_CNT_W-1:0] rx_fill   [CHANNELS] = '{default: '0};
  logic                rx_ovf    [CHANNELS] = '{default: 1'b0};
  logic [TX_PTR_W-1:0] tx_wr_ptr [CHANNELS] = '{default: '0};
  logic [TX_PTR_W-1:0] tx_rd_ptr [CHANNELS] = '{default: '0};
  logic [TX_CNT_W-1:0] tx_fill   [CHANNELS] = '{default: '0};
  logic                tx_busy   [CHANNELS] = '{default: 1'b0};

  uart_result_t ring_results_q [$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           words_sent  = 0;
  bit           calm        = 1'b0;

  // Directed words; rows marked fixed carry the response read straight off the spec
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_READ,    1'b0, 8'h00, 1'b1, ST_EMPTY, 8'h00, 1'b0, 8'h00},
    '{OP_READ,    1'b1, 8'h00, 1'b1, ST_EMPTY, 8'h00, 1'b0, 8'h00},
    '{OP_TXEMPTY, 1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_WRITE,   1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 1'b1, 8'h00},
    '{OP_WRITE,   1'b0, 8'hFF, 1'b1, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_WRITE,   1'b0, 8'hA5, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_TXEMPTY, 1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 1'b1, 8'hFF},
    '{OP_TXEMPTY, 1'b0, 8'h00, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_TXEMPTY, 1'b0, 8'h00, 1'b1, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_WRITE,   1'b1, 8'h80, 1'b1, ST_OK,    8'h00, 1'b1, 8'h80},
    '{OP_RECV,    1'b1, 8'h00, 1'b1, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_RECV,    1'b1, 8'hFF, 1'b1, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_RECV,    1'b0, 8'h5A, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_READ,    1'b1, 8'h00, 1'b1, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_READ,    1'b1, 8'h00, 1'b1, ST_OK,    8'hFF, 1'b0, 8'h00},
    '{OP_READ,    1'b1, 8'h00, 1'b1, ST_EMPTY, 8'h00, 1'b0, 8'h00},
    '{OP_READ,    1'b0, 8'h00, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_TXEMPTY, 1'b1, 8'h00, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_WRITE,   1'b1, 8'h01, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_RECV,    1'b0, 8'h7F, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00},
    '{OP_READ,    1'b0, 8'h00, 1'b0, ST_OK,    8'h00, 1'b0, 8'h00}
  };

  // Advance the ring state by one event and return the response it owes
  function automatic uart_result_t ring_update(op_t op, logic [CH_W-1:0] ch,
                                               logic [BYTE_W-1:0] data);
    uart_result_t r;
    r = '{status: ST_OK, read_data: '0, line_valid: 1'b0, line_byte: '0};
    if (ch < CHANNELS) begin
      case (op)
        OP_WRITE: begin
          // full test comes before the busy test
          if (tx_fill[ch] >= TX_DEPTH) begin
            r.status = ST_FULL;
          end else if (!tx_busy[ch]) begin
            r.line_valid = 1'b1;
            r.line_byte  = data;
            tx_busy[ch]  = 1'b1;
          end else begin
            tx_ring[ch][tx_wr_ptr[ch]] = data;
            tx_wr_ptr[ch] = (tx_wr_ptr[ch] == TX_DEPTH - 1) ? '0 : tx_wr_ptr[ch] + 1'b1;
            tx_fill[ch]++;
          end
        end
        OP_READ: begin
          // sticky overflow blocks the pop
          if (rx_ovf[ch]) begin
            r.status = ST_OVERFLOW;
          end else if (rx_fill[ch] != 0) begin
            r.read_data = rx_ring[ch][rx_rd_ptr[ch]];
            rx_rd_ptr[ch] = (rx_rd_ptr[ch] == RX_DEPTH - 1) ? '0 : rx_rd_ptr[ch] + 1'b1;
            rx_fill[ch]--;
          end else begin
            r.status = ST_EMPTY;
          end
        end
        OP_RECV: begin
          if (rx_fill[ch] >= RX_DEPTH) begin
            rx_ovf[ch] = 1'b1;
          end else begin
            rx_ring[ch][rx_wr_ptr[ch]] = data;
            rx_wr_ptr[ch] = (rx_wr_ptr[ch] == RX_DEPTH - 1) ? '0 : rx_wr_ptr[ch] + 1'b1;
            rx_fill[ch]++;
            rx_ovf[ch] = 1'b0;
          end
        end
        default: begin
          // transmitter empty: next queued byte, or go idle
          if (tx_fill[ch] != 0) begin
            r.line_valid = 1'b1;
            r.line_byte  = tx_ring[ch][tx_rd_ptr[ch]];
            tx_rd_ptr[ch] = (tx_rd_ptr[ch] == TX_DEPTH - 1) ? '0 : tx_rd_ptr[ch] + 1'b1;
            tx_fill[ch]--;
            tx_busy[ch] = 1'b1;
          end else begin
            tx_busy[ch] = 1'b0;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Present one request word after a random gap; predict its response once taken
  task automatic send_word(op_t op, logic [CH_W-1:0] ch, logic [BYTE_W-1:0] data,
                           bit fixed, uart_result_t fixed_res);
    int           gap;
    uart_result_t pred;
    gap = draw_gap();
    @(negedge clk);
    repeat (gap) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.op      = op;
    req_bus.channel = ch;
    req_bus.data    = data;
    req_bus.valid   = 1'b1;
    do @(posedge clk); while (!req_bus.ready);
    pred = ring_update(op, ch, data);
    ring_results_q.push_back(fixed ? fixed_res : pred);
    // flip between idling and back-to-back stretches now and then
    words_sent++;
    if (words_sent % 97 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_burst(op_t op, logic [CH_W-1:0] ch, int n);
    repeat (n) send_word(op, ch, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Response sink: random stall before each word
  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = draw_gap();
      @(negedge clk);
      repeat (stall) begin
        rsp_bus.ready = 1'b0;
        @(negedge clk);
      end
      rsp_bus.ready = 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // Compare each taken response with the oldest prediction
  always @(posedge clk) begin : check_resp
    uart_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (ring_results_q.size() == 0) begin
        report_mismatch("response with nothing owed, status", int'(rsp_bus.status), 0);
      end else begin
        want = ring_results_q.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch("status", int'(rsp_bus.status), int'(want.status));
        if (rsp_bus.read_data !== want.read_data)
          report_mismatch("read_data", int'(rsp_bus.read_data), int'(want.read_data));
        if (rsp_bus.line_valid !== want.line_valid)
          report_mismatch("line_valid", int'(rsp_bus.line_valid), int'(want.line_valid));
        if (rsp_bus.line_byte !== want.line_byte)
          report_mismatch("line_byte", int'(rsp_bus.line_byte), int'(want.line_byte));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    uart_result_t     fixed_res;
    logic [CH_W-1:0]  tx_ch;
    logic [CH_W-1:0]  rx_ch;
    op_t              op;
    req_bus.valid   = 1'b0;
    req_bus.op      = OP_WRITE;
    req_bus.channel = '0;
    req_bus.data    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      fixed_res = '{status: dir_rows[i].st, read_data: dir_rows[i].rd,
                    line_valid: dir_rows[i].lv, line_byte: dir_rows[i].lb};
      send_word(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].data, dir_rows[i].fixed,
                fixed_res);
    end

    // Random mix on both channels; counts wander near empty
    repeat (RANDOM_WORDS) begin
      op = op_t'($urandom_range(0, 3));
      send_word(op, CH_W'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                1'b0, '0);
    end

    // Transmit ring: queue a run behind the busy line, drain it, then go idle
    tx_ch = CH_W'($urandom_range(0, 1));
    send_burst(OP_WRITE, tx_ch, 17);
    send_burst(OP_TXEMPTY, tx_ch, 24);

    // Receive ring: a run of received bytes, read back until empty
    rx_ch = CH_W'($urandom_range(0, 1));
    send_burst(OP_RECV, rx_ch, 16);
    send_burst(OP_READ, rx_ch, 22);

    @(negedge clk);
    req_bus.valid = 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
